// File: rtl/core/parity_split_two_to_one_queue_merge_top_assert.svh
// Assertion macros used by the checker file pstq_chk.sv.
`ifndef PARITY_SPLIT_TWO_TO_ONE_QUEUE_MERGE_TOP_ASSERT_SVH
`define PARITY_SPLIT_TWO_TO_ONE_QUEUE_MERGE_TOP_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define PSTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PSTQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pstq_pkg.sv
`default_nettype none

package pstq_pkg;

  localparam int unsigned ITEM_W     = 16;
  localparam int unsigned FAST_BURST = 2;
  localparam int unsigned BURST_W    = 2;

  typedef struct packed {
    logic [ITEM_W-1:0] served_number;
    logic              final_result;
    logic              dropped_any;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/pstq_stream_if.sv
`default_nettype none

interface pstq_in_if;
  logic                          valid;
  logic                          ready;
  logic [pstq_pkg::ITEM_W-1:0]   item_number;
  logic                          batch_end;

  modport source (output valid, output item_number, output batch_end, input ready);
  modport sink (input valid, input item_number, input batch_end, output ready);
endinterface

interface pstq_out_if;
  logic                          valid;
  logic                          ready;
  logic [pstq_pkg::ITEM_W-1:0]   served_number;
  logic                          final_result;
  logic                          dropped_any;

  modport source (output valid, output served_number, output final_result,
                  output dropped_any, input ready);
  modport sink (input valid, input served_number, input final_result,
                input dropped_any, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pstq_ram.sv
`default_nettype none

module pstq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/parity_split_two_to_one_queue_merge_top.sv
// Load: one item per cycle, written into the odd or even RAM at its fill count.
// Drain starts the cycle after the batch_end beat; each result passes the RAM read register and the output buffer.
// Drain: one result per cycle while the output is not stalled, each read going to one of the two RAMs;
// input is held off for the whole drain, which output stalls lengthen.
// Reset clears counts, drop flag, drain state and output buffer; RAM contents stay.
`default_nettype none

module parity_split_two_to_one_queue_merge_top #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pstq_in_if.sink     in_i,
  pstq_out_if.source  out_o
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned IW = pstq_pkg::ITEM_W;
  localparam int unsigned BW = pstq_pkg::BURST_W;

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state_q, state_d;
  logic [CW-1:0] odd_cnt_q, odd_cnt_d, even_cnt_q, even_cnt_d;
  logic [CW-1:0] fh_q, fh_d, sh_q, sh_d;
  logic [BW-1:0] burst_q, burst_d;
  logic          ovf_q, ovf_d;

  logic          pend_q, pend_fast_q, pend_final_q, pend_drop_q;

  pstq_pkg::result_t fifo_q [2];
  logic              wptr_q, rptr_q;
  logic [1:0]        fcnt_q, fcnt_d;

  logic          in_acc, is_odd, odd_full, even_full, odd_we, even_we;
  logic          fast_left, slow_left, pick_fast, issue, last_issue, push, pop;
  logic [1:0]    occ;
  logic [CW-1:0] fh_n, sh_n;
  logic [IW-1:0] odd_rdata, even_rdata;
  pstq_pkg::result_t push_data;

  assign in_i.ready = (state_q == ST_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_odd     = in_i.item_number[0];
  assign odd_full   = (odd_cnt_q == CW'(QUEUE_DEPTH));
  assign even_full  = (even_cnt_q == CW'(QUEUE_DEPTH));
  assign odd_we     = in_acc && is_odd && !odd_full;
  assign even_we    = in_acc && !is_odd && !even_full;

  assign fast_left  = (fh_q < odd_cnt_q);
  assign slow_left  = (sh_q < even_cnt_q);
  assign pick_fast  = fast_left && (!slow_left || (burst_q < BW'(pstq_pkg::FAST_BURST)));

  assign pop   = out_o.valid && out_o.ready;
  assign push  = pend_q;
  assign occ   = fcnt_q + {1'b0, pend_q} - {1'b0, pop};
  assign issue = (state_q == ST_DRAIN) && (occ <= 2'd1);

  assign fh_n       = fh_q + CW'(pick_fast);
  assign sh_n       = sh_q + CW'(!pick_fast);
  assign last_issue = (fh_n == odd_cnt_q) && (sh_n == even_cnt_q);

  pstq_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_odd_ram (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .waddr_i (odd_cnt_q[AW-1:0]),
    .wdata_i (in_i.item_number),
    .re_i    (issue && pick_fast),
    .raddr_i (fh_q[AW-1:0]),
    .rdata_o (odd_rdata)
  );

  pstq_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_even_ram (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .waddr_i (even_cnt_q[AW-1:0]),
    .wdata_i (in_i.item_number),
    .re_i    (issue && !pick_fast),
    .raddr_i (sh_q[AW-1:0]),
    .rdata_o (even_rdata)
  );

  always_comb begin
    state_d    = state_q;
    odd_cnt_d  = odd_cnt_q;
    even_cnt_d = even_cnt_q;
    fh_d       = fh_q;
    sh_d       = sh_q;
    burst_d    = burst_q;
    ovf_d      = ovf_q;
    case (state_q)
      ST_LOAD: begin
        if (odd_we) begin
          odd_cnt_d = odd_cnt_q + CW'(1);
        end
        if (even_we) begin
          even_cnt_d = even_cnt_q + CW'(1);
        end
        if (in_acc && ((is_odd && odd_full) || (!is_odd && even_full))) begin
          ovf_d = 1'b1;
        end
        if (in_acc && in_i.batch_end) begin
          state_d = ST_DRAIN;
          fh_d    = '0;
          sh_d    = '0;
          burst_d = '0;
        end
      end
      ST_DRAIN: begin
        if (issue) begin
          fh_d = fh_n;
          sh_d = sh_n;
          if (!pick_fast) begin
            burst_d = '0;
          end else if (slow_left) begin
            burst_d = burst_q + BW'(1);
          end
          if (last_issue) begin
            state_d    = ST_LOAD;
            odd_cnt_d  = '0;
            even_cnt_d = '0;
            ovf_d      = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      odd_cnt_q  <= '0;
      even_cnt_q <= '0;
      fh_q       <= '0;
      sh_q       <= '0;
      burst_q    <= '0;
      ovf_q      <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      odd_cnt_q  <= odd_cnt_d;
      even_cnt_q <= even_cnt_d;
      fh_q       <= fh_d;
      sh_q       <= sh_d;
      burst_q    <= burst_d;
      ovf_q      <= ovf_d;
      pend_q     <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_fast_q  <= pick_fast;
      pend_final_q <= last_issue;
      pend_drop_q  <= ovf_q;
    end
  end

  // output buffer: two entries, so the read already in flight when the output stalls still has a slot
  assign push_data.served_number = pend_fast_q ? odd_rdata : even_rdata;
  assign push_data.final_result  = pend_final_q;
  assign push_data.dropped_any   = pend_drop_q;
  assign fcnt_d = fcnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fcnt_q <= '0;
    end else begin
      fcnt_q <= fcnt_d;
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= push_data;
    end
  end

  assign out_o.valid         = (fcnt_q != 2'd0);
  assign out_o.served_number = fifo_q[rptr_q].served_number;
  assign out_o.final_result  = fifo_q[rptr_q].final_result;
  assign out_o.dropped_any   = fifo_q[rptr_q].dropped_any;

endmodule

`default_nettype wire

// File: rtl/core/pstq_chk.sv
`default_nettype none

`include "parity_split_two_to_one_queue_merge_top_assert.svh"

module pstq_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        in_batch_end_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [pstq_pkg::ITEM_W-1:0] out_served_number_i,
  input wire logic                        out_final_result_i,
  input wire logic                        out_dropped_any_i
);

  logic in_acc, out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  `PSTQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_served_number_i) && $stable(out_final_result_i) && $stable(out_dropped_any_i), "stalled result beat changed")
  `PSTQ_ASSERT_NEXT(a_drain_blocks_input, clk_i, rst_ni, in_acc && in_batch_end_i, !in_ready_i, "input not held off after batch end")
  `PSTQ_ASSERT_NEXT(a_load_keeps_ready, clk_i, rst_ni, in_acc && !in_batch_end_i, in_ready_i, "input blocked in mid batch")

endmodule

bind parity_split_two_to_one_queue_merge_top pstq_chk u_pstq_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .in_batch_end_i      (in_i.batch_end),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_served_number_i (out_o.served_number),
  .out_final_result_i  (out_o.final_result),
  .out_dropped_any_i   (out_o.dropped_any)
);

`default_nettype wire

// File: sim/pstq_service_checker.sv
module pstq_service_checker #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pstq_in_if        in_mon_i,
  pstq_out_if       out_mon_i,
  output int        errors_o,
  output int        pending_o,
  output int        served_o,
  output int        batches_o,
  output int        overflow_batches_o
);

  localparam int unsigned IW = pstq_pkg::ITEM_W;

  logic [IW-1:0]     fast_lane[$];
  logic [IW-1:0]     slow_lane[$];
  logic              overflow_flag;
  pstq_pkg::result_t service_plan[$];

  // Queue or drop one beat; on the batch end, lay out the 2:1 service order.
  function automatic void stage_item(input logic [IW-1:0] num, input logic last);
    logic [IW-1:0]     order[$];
    int                fh;
    int                sh;
    int                b;
    int                k;
    pstq_pkg::result_t r;
    if (num[0]) begin
      if (fast_lane.size() < QUEUE_DEPTH) fast_lane.push_back(num);
      else overflow_flag = 1'b1;
    end else begin
      if (slow_lane.size() < QUEUE_DEPTH) slow_lane.push_back(num);
      else overflow_flag = 1'b1;
    end
    if (!last) return;
    fh = 0;
    sh = 0;
    while (fh < fast_lane.size() && sh < slow_lane.size()) begin
      for (b = 0; b < pstq_pkg::FAST_BURST && fh < fast_lane.size(); b++) begin
        order.push_back(fast_lane[fh]);
        fh++;
      end
      order.push_back(slow_lane[sh]);
      sh++;
    end
    while (fh < fast_lane.size()) begin
      order.push_back(fast_lane[fh]);
      fh++;
    end
    while (sh < slow_lane.size()) begin
      order.push_back(slow_lane[sh]);
      sh++;
    end
    for (k = 0; k < order.size(); k++) begin
      r.served_number = order[k];
      r.final_result  = (k == order.size() - 1);
      r.dropped_any   = overflow_flag;
      service_plan.push_back(r);
    end
    batches_o++;
    if (overflow_flag) overflow_batches_o++;
    fast_lane.delete();
    slow_lane.delete();
    overflow_flag = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pstq_pkg::result_t exp_r;
    if (!rst_ni) begin
      fast_lane.delete();
      slow_lane.delete();
      service_plan.delete();
      overflow_flag = 1'b0;
      pending_o     = 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        served_o++;
        if (service_plan.size() == 0) begin
          $error("result beat with nothing expected: served_number %h",
                 out_mon_i.served_number);
          errors_o++;
        end else begin
          exp_r = service_plan.pop_front();
          if (out_mon_i.served_number !== exp_r.served_number) begin
            $error("served_number mismatch: expected %h, actual %h",
                   exp_r.served_number, out_mon_i.served_number);
            errors_o++;
          end
          if (out_mon_i.final_result !== exp_r.final_result) begin
            $error("final_result mismatch: expected %b, actual %b",
                   exp_r.final_result, out_mon_i.final_result);
            errors_o++;
          end
          if (out_mon_i.dropped_any !== exp_r.dropped_any) begin
            $error("dropped_any mismatch: expected %b, actual %b",
                   exp_r.dropped_any, out_mon_i.dropped_any);
            errors_o++;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        stage_item(in_mon_i.item_number, in_mon_i.batch_end);
      end
      pending_o = service_plan.size();
    end
  end

endmodule

// File: sim/parity_split_two_to_one_queue_merge_top_tb.sv
module parity_split_two_to_one_queue_merge_top_tb;

  localparam int CLK_PERIOD   = 12;
  localparam int DEPTH        = 32;
  localparam int RANDOM_ITEMS = 250;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int IW           = pstq_pkg::ITEM_W;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int items_sent     = 0;

  int errors;
  int pending;
  int served;
  int batches;
  int overflow_batches;

  pstq_in_if  in_bus ();
  pstq_out_if out_bus ();

  parity_split_two_to_one_queue_merge_top #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  pstq_service_checker #(
    .QUEUE_DEPTH(DEPTH)
  ) checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_mon_i          (in_bus),
    .out_mon_i         (out_bus),
    .errors_o          (errors),
    .pending_o         (pending),
    .served_o          (served),
    .batches_o         (batches),
    .overflow_batches_o(overflow_batches)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    #(CLK_PERIOD * 200000);
    $display("parity_split_two_to_one_queue_merge_top test failed");
    $finish;
  end

  // Receiver: honor a long hold-off request, else stall at the phase rate.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Enter and leave at a falling edge; valid stays high across back-to-back beats.
  task automatic send_beat(input logic [IW-1:0] num, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.item_number <= num;
    in_bus.batch_end   <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random_batch();
    int            len;
    int            shape;
    int            odd_pct;
    int            i;
    logic [IW-1:0] num;
    shape = $urandom_range(99);
    if (shape < 55) begin
      len     = $urandom_range(8, 1);
      odd_pct = 50;
    end else if (shape < 85) begin
      len     = $urandom_range(24, 9);
      odd_pct = $urandom_range(90, 10);
    end else if (shape < 95) begin
      len     = DEPTH + $urandom_range(6, 1);
      odd_pct = $urandom_range(1) ? 92 : 8;
    end else begin
      len     = 2 * DEPTH + $urandom_range(4, 1);
      odd_pct = 50;
    end
    for (i = 0; i < len; i++) begin
      num    = IW'($urandom_range(16'hFFFF, 0));
      num[0] = ($urandom_range(99) < odd_pct);
      send_beat(num, i == len - 1);
    end
  endtask

  initial begin
    int base;
    int phase;
    int i;
    int guard;
    in_bus.valid       <= 1'b0;
    in_bus.item_number <= '0;
    in_bus.batch_end   <= 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_beat(16'h0001, 1'b1);
    send_beat(16'h0000, 1'b1);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'hFFFE, 1'b1);
    // one fast item left in the round-robin
    send_beat(16'h8001, 1'b0);
    send_beat(16'h0002, 1'b0);
    send_beat(16'h7FFF, 1'b0);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h5555, 1'b1);
    send_beat(16'h2AAA, 1'b0);
    send_beat(16'h0010, 1'b0);
    send_beat(16'hFFFE, 1'b1);
    send_beat(16'hAAAB, 1'b0);
    send_beat(16'h0003, 1'b1);
    send_beat(16'h0101, 1'b0);
    send_beat(16'h0103, 1'b0);
    send_beat(16'h0004, 1'b0);
    send_beat(16'h0105, 1'b0);
    send_beat(16'h0107, 1'b1);

    // Overflow the fast queue, drop the batch end itself, and stall the drain.
    hold_req = 1'b1;
    for (i = 0; i < DEPTH + 2; i++) begin
      send_beat(IW'($urandom_range(16'hFFFF, 0)) | IW'(1), i == DEPTH + 1);
    end
    send_random_batch();

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      phase = (items_sent - base) * 4 / RANDOM_ITEMS;
      case (phase)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 53;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 53;
        end
        default: begin
          src_idle_pct   = 22;
          sink_stall_pct = 22;
        end
      endcase
      send_random_batch();
    end
    in_bus.valid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    if (pending != 0) begin
      $display("parity_split_two_to_one_queue_merge_top test failed");
    end else begin
      repeat (12) @(negedge clk_i);
      $display("Sent %0d item beats in %0d batches, %0d of them overflowing a queue;",
               items_sent, batches, overflow_batches);
      $display("checked %0d served beats under four idle/stall mixes and a long hold-off.",
               served);
      if (errors == 0 && pending == 0) begin
        $display("parity_split_two_to_one_queue_merge_top test passed");
      end else begin
        $display("parity_split_two_to_one_queue_merge_top test failed");
      end
    end
    $finish;
  end

endmodule
